// File: hdl/reversible_deque_engine_assert.svh
// Assertion macros for the deque engine RTL
`ifndef REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH
`define REVERSIBLE_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rde_pkg.sv
// Package: operation codes and result status type for the deque engine
`timescale 1ns / 1ps

package rde_pkg;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_REVERSE = 3'd2,
    OP_DELETE  = 3'd3,
    OP_DRAIN   = 3'd4
  } op_t;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 11;

  // Status of one item, handed from the controller to the result stages
  typedef struct packed {
    logic               pop;
    logic               err;
    logic               ovf;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

// File: hdl/reversible_deque_engine.sv
// Top level: double-ended queue with reverse flag, store, result stage and output register
`timescale 1ns / 1ps

// Ring-buffer deque of DEPTH elements held in one synchronous RAM. Each
// accepted word (clear, append, reverse, delete, drain) updates the pointers
// and flags in the cycle it is taken and yields exactly one result word. The
// block takes one word per cycle while in_stall is low; a result passes
// through the read stage, alongside the element RAM's registered read data,
// then the output register. A stalled output holds the result in the output
// register and the RAM read data; input is stalled only when both are full.
// No clearing pass runs after reset: clear only rewinds pointers and flags.
`include "reversible_deque_engine_assert.svh"

module reversible_deque_engine #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rde_pkg::FUNC_W-1:0]          in_func,
  input  logic [rde_pkg::VALUE_W-1:0]         in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rde_pkg::VALUE_W-1:0]         out_out_value,
  output logic                                out_out_valid,
  output logic                                out_error_flag,
  output logic                                out_overflow_flag,
  output logic [rde_pkg::COUNT_W-1:0]         out_element_count
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic                  accept;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [PW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  rde_pkg::rsp_t         rsp;

  logic                  s1_valid_r;
  rde_pkg::rsp_t         s1_rsp_r;
  logic                  s1_move;
  logic                  out_free;

  logic                          out_valid_r;
  logic [rde_pkg::VALUE_W-1:0]   out_value_r;
  rde_pkg::rsp_t                 out_rsp_r;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  rde_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .value     (in_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .rsp       (rsp)
  );

  rde_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read stage: status waits here alongside the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rsp_r <= rsp;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_rsp_r   <= s1_rsp_r;
      out_value_r <= s1_rsp_r.pop ? rde_pkg::VALUE_W'(mem_rdata) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_value     = out_value_r;
  assign out_out_valid     = out_rsp_r.pop;
  assign out_error_flag    = out_rsp_r.err;
  assign out_overflow_flag = out_rsp_r.ovf;
  assign out_element_count = out_rsp_r.count;

  // Checks
  `RDE_ASSERT_NOW(a_value_zero_without_pop, out_valid && !out_out_valid, out_out_value == '0, "value without pop")
  `RDE_ASSERT_NOW(a_pop_excludes_overflow, out_valid, !(out_out_valid && out_overflow_flag), "pop and overflow together")
  `RDE_ASSERT_NOW(a_interlock, s1_valid_r && out_valid && out_stall, in_stall, "input taken with both stages full")
  `RDE_ASSERT_NEXT(a_read_stage_holds, s1_valid_r && !s1_move, s1_valid_r, "read stage lost a word")

endmodule

// File: hdl/rde_mem.sv
// Element store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module rde_mem #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] store_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rde_ctrl.sv
// Deque controller: pointers, flags and store access for each accepted word
`timescale 1ns / 1ps

module rde_ctrl #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [rde_pkg::FUNC_W-1:0]           func,
  input  logic [rde_pkg::VALUE_W-1:0]          value,
  output logic                                 mem_we,
  output logic [$clog2(DEPTH)-1:0]             mem_waddr,
  output logic [DATA_WIDTH-1:0]                mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(DEPTH)-1:0]             mem_raddr,
  output rde_pkg::rsp_t                        rsp
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          err_r, err_nxt;
  logic          ovf;
  logic          pop;
  logic          full;
  logic          empty;

  // Physical index of head + offset, wrapped once at DEPTH
  function automatic logic [PW-1:0] ring(input logic [PW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return PW'(sum);
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Next state and store access
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    err_nxt   = err_r;
    ovf       = 1'b0;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ring(head_r, count_r);
    mem_wdata = DATA_WIDTH'(value);
    mem_raddr = rev_r ? ring(head_r, count_r - CW'(1)) : head_r;
    if (accept) begin
      unique case (rde_pkg::op_t'(func))
        rde_pkg::OP_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
          err_nxt   = 1'b0;
        end
        rde_pkg::OP_APPEND: begin
          if (!err_r) begin
            if (full) begin
              ovf = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
        end
        rde_pkg::OP_REVERSE: begin
          if (!err_r) begin
            rev_nxt = !rev_r;
          end
        end
        rde_pkg::OP_DELETE: begin
          if (!err_r) begin
            if (empty) begin
              err_nxt = 1'b1;
            end else begin
              count_nxt = count_r - CW'(1);
              if (!rev_r) begin
                head_nxt = ring(head_r, CW'(1));
              end
            end
          end
        end
        rde_pkg::OP_DRAIN: begin
          if (!empty) begin
            mem_re    = 1'b1;
            pop       = 1'b1;
            count_nxt = count_r - CW'(1);
            if (!rev_r) begin
              head_nxt = ring(head_r, CW'(1));
            end
          end
        end
        default: begin
          // unused codes report status only
        end
      endcase
    end
  end

  // Status after this word
  assign rsp.pop   = pop;
  assign rsp.err   = err_nxt;
  assign rsp.ovf   = ovf;
  assign rsp.count = rde_pkg::COUNT_W'(count_nxt);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
